>>> hw/rtl/iot_pkg.sv
package iot_pkg;

    localparam int VALUE_W     = 8;
    localparam int OP_W        = 3;
    localparam int DIM_REG_W   = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [VALUE_W-1:0]   MAX_LEVEL     = 8'd255;
    localparam logic [DIM_REG_W-1:0] DIM_RESET     = 9'd256;

    // Operation codes; the remaining codes pass the frame through unchanged.
    localparam logic [OP_W-1:0] OP_INVERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_MIRROR  = 3'd1;
    localparam logic [OP_W-1:0] OP_FLIP    = 3'd2;
    localparam logic [OP_W-1:0] OP_ROT_CW  = 3'd3;
    localparam logic [OP_W-1:0] OP_ROT_CCW = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OPERATION = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_COLOR     = 2'd3
    } reg_index_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        SYNC_SETTLE = 2'd0,
        SYNC_CHAN   = 2'd1,
        SYNC_PIX    = 2'd2,
        SYNC_RUN    = 2'd3
    } sync_state_t;

endpackage

>>> hw/rtl/iot_if.sv
interface iot_item_if import iot_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface iot_result_if import iot_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] pixel_byte;
    logic               last;

    modport source (output valid, output pixel_byte, output last, input ready);
    modport sink   (input valid, input pixel_byte, input last, output ready);
endinterface

interface iot_cfg_if import iot_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/iot_div.sv
module iot_div import iot_pkg::*; #(
    parameter int NW = 18,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          q_bit;
    logic [DW-1:0] rem_next;

    // One restoring step per cycle: shift in the next dividend bit, try to subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        q_bit    = ~diff[DW];
        rem_next = q_bit ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1)) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/iot_queue.sv
module iot_queue import iot_pkg::*; #(
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] data_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = data_reg[rd_ptr_reg];
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

>>> hw/rtl/iot_front.sv
module iot_front import iot_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    iot_item_if.sink                                   item,
    iot_cfg_if.sink                                    cfg,
    output logic                                       push,
    output logic [ 13 + $clog2(MAX_WIDTH + 1) + $clog2(MAX_HEIGHT + 1)
                   + $clog2(MAX_WIDTH * MAX_HEIGHT * 3) - 1 : 0 ] push_data,
    input  logic                                       q_full,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]           frame_w,
    output logic                                       rgb
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int OW    = (WW > HW) ? WW : HW;
    localparam int DW    = (OW > 2) ? OW : 2;

    typedef struct packed {
        logic               is_read;
        logic               invert;
        logic               last;
        logic [1:0]         chan;
        logic [WW-1:0]      sx;
        logic [HW-1:0]      sy;
        logic [AW-1:0]      waddr;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // configuration
    logic [OP_W-1:0]      op_reg, op_next;
    logic [DIM_REG_W-1:0] width_reg, width_next;
    logic [DIM_REG_W-1:0] height_reg, height_next;
    logic                 color_reg, color_next;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW+HW-1:0] wh_prod;
    logic [TW-1:0] wh_reg;
    logic [TW-1:0] total_reg;
    logic          rotate;
    logic [OW-1:0] ow;
    logic [OW-1:0] oh;
    logic [1:0]    chan_cnt;
    logic [1:0]    chan_max;

    // position tracking
    sync_state_t   state_reg, state_next;
    logic [1:0]    settle_reg, settle_next;
    logic [TW-1:0] wpos_reg, wpos_next;
    logic [AW-1:0] rpos_reg, rpos_next;
    logic [1:0]    k_reg, k_next;
    logic [OW-1:0] ox_reg, ox_next;
    logic [OW-1:0] oy_reg, oy_next;

    logic          item_acc;
    logic          cfg_acc;
    logic          loaded;
    logic          last_byte;
    logic          rpos_past;
    entry_t        entry;

    logic          div_start;
    logic [AW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [AW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    // clamp the frame dimensions
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_reg);
        end
    end

    assign wh_prod  = w_eff * h_eff;
    assign rotate   = (op_reg == OP_ROT_CW) || (op_reg == OP_ROT_CCW);
    assign ow       = rotate ? OW'(h_eff) : OW'(w_eff);
    assign oh       = rotate ? OW'(w_eff) : OW'(h_eff);
    assign chan_cnt = color_reg ? 2'd3 : 2'd1;
    assign chan_max = color_reg ? 2'd2 : 2'd0;

    // frame size: product, then times channels
    always_ff @(posedge clk)
    begin
        wh_reg    <= TW'(wh_prod);
        total_reg <= color_reg ? (wh_reg + {wh_reg[TW-2:0], 1'b0}) : wh_reg;
    end

    assign item_acc  = item.valid && item.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign loaded    = (wpos_reg >= total_reg);
    assign last_byte = (k_reg == chan_max) && (ox_reg == ow - OW'(1))
                       && (oy_reg == oh - OW'(1));
    // a saved read position past the current frame acts as the first byte
    assign rpos_past = (TW'(rpos_reg) >= total_reg);

    assign item.ready = (state_reg == SYNC_RUN) && !q_full;
    assign cfg.ready  = 1'b1;

    // source coordinates for the current output position
    always_comb
    begin
        entry         = '0;
        entry.is_read = (item.action == ACT_READ);
        entry.invert  = (op_reg == OP_INVERT);
        entry.last    = last_byte;
        entry.chan    = k_reg;
        entry.waddr   = AW'(wpos_reg);
        entry.value   = item.value;
        unique case (op_reg)
            OP_MIRROR:
            begin
                entry.sx = w_eff - WW'(1) - WW'(ox_reg);
                entry.sy = HW'(oy_reg);
            end
            OP_FLIP:
            begin
                entry.sx = WW'(ox_reg);
                entry.sy = h_eff - HW'(1) - HW'(oy_reg);
            end
            OP_ROT_CW:
            begin
                entry.sx = WW'(oy_reg);
                entry.sy = h_eff - HW'(1) - HW'(ox_reg);
            end
            OP_ROT_CCW:
            begin
                entry.sx = w_eff - WW'(1) - WW'(oy_reg);
                entry.sy = HW'(ox_reg);
            end
            default:
            begin
                entry.sx = WW'(ox_reg);
                entry.sy = HW'(oy_reg);
            end
        endcase
    end

    assign push_data = entry;

    assign div_dividend = (state_reg == SYNC_SETTLE) ? rpos_reg : div_quo;
    assign div_divisor  = (state_reg == SYNC_SETTLE) ? DW'(chan_cnt) : DW'(ow);

    iot_div #(
        .NW (AW),
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SYNC_SETTLE;
            settle_reg <= '0;
            wpos_reg   <= '0;
            rpos_reg   <= '0;
            k_reg      <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            op_reg     <= OP_INVERT;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            color_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
            wpos_reg   <= wpos_next;
            rpos_reg   <= rpos_next;
            k_reg      <= k_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            op_reg     <= op_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            color_reg  <= color_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        settle_next = settle_reg;
        wpos_next   = wpos_reg;
        rpos_next   = rpos_reg;
        k_next      = k_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        op_next     = op_reg;
        width_next  = width_reg;
        height_next = height_reg;
        color_next  = color_reg;
        div_start   = 1'b0;
        push        = 1'b0;

        unique case (state_reg)
            SYNC_SETTLE:
            begin
                // let the frame size settle through wh_reg and total_reg, then split the read position
                if (settle_reg != 2'd2)
                begin
                    settle_next = settle_reg + 2'd1;
                end
                else if (rpos_past)
                begin
                    k_next     = '0;
                    ox_next    = '0;
                    oy_next    = '0;
                    state_next = SYNC_RUN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = SYNC_CHAN;
                end
            end
            SYNC_CHAN:
            begin
                if (div_done)
                begin
                    k_next     = div_rem[1:0];
                    div_start  = 1'b1;
                    state_next = SYNC_PIX;
                end
            end
            SYNC_PIX:
            begin
                if (div_done)
                begin
                    ox_next    = OW'(div_rem);
                    oy_next    = OW'(div_quo);
                    state_next = SYNC_RUN;
                end
            end
            SYNC_RUN:
            begin
                if (item_acc)
                begin
                    if (item.action == ACT_WRITE)
                    begin
                        // drop writes past the frame
                        if (!loaded)
                        begin
                            push      = 1'b1;
                            wpos_next = wpos_reg + TW'(1);
                        end
                    end
                    else if (loaded)
                    begin
                        push      = 1'b1;
                        if (last_byte)
                        begin
                            rpos_next = '0;
                        end
                        else if (rpos_past)
                        begin
                            rpos_next = AW'(1);
                        end
                        else
                        begin
                            rpos_next = rpos_reg + AW'(1);
                        end
                        if (k_reg == chan_max)
                        begin
                            k_next = '0;
                            if (ox_reg == ow - OW'(1))
                            begin
                                ox_next = '0;
                                oy_next = (oy_reg == oh - OW'(1)) ? '0 : oy_reg + OW'(1);
                            end
                            else
                            begin
                                ox_next = ox_reg + OW'(1);
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = SYNC_SETTLE;
            end
        endcase

        if (cfg_acc)
        begin
            state_next  = SYNC_SETTLE;
            settle_next = '0;
            unique case (cfg.index)
                REG_OPERATION: op_next     = cfg.data[OP_W-1:0];
                REG_WIDTH:     width_next  = cfg.data[DIM_REG_W-1:0];
                REG_HEIGHT:    height_next = cfg.data[DIM_REG_W-1:0];
                REG_COLOR:     color_next  = cfg.data[0];
                default:       op_next     = op_reg;
            endcase
        end
    end

    assign frame_w = w_eff;
    assign rgb     = color_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SYNC_RUN) |-> (k_reg <= chan_max && ox_reg < ow && oy_reg < oh))
        else $error("output position outside the transformed frame");

    a_origin_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SYNC_RUN && rpos_reg == '0)
            |-> (k_reg == '0 && ox_reg == '0 && oy_reg == '0))
        else $error("read position and coordinates disagree at frame start");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("transaction pushed into a full queue");

endmodule

>>> hw/rtl/iot_back.sv
module iot_back import iot_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [ 13 + $clog2(MAX_WIDTH + 1) + $clog2(MAX_HEIGHT + 1)
                   + $clog2(MAX_WIDTH * MAX_HEIGHT * 3) - 1 : 0 ] pop_data,
    input  logic                                       q_empty,
    output logic                                       pop,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]           frame_w,
    input  logic                                       rgb,
    iot_result_if.source                               result
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    typedef struct packed {
        logic               is_read;
        logic               invert;
        logic               last;
        logic [1:0]         chan;
        logic [WW-1:0]      sx;
        logic [HW-1:0]      sy;
        logic [AW-1:0]      waddr;
        logic [VALUE_W-1:0] value;
    } entry_t;

    entry_t             head;
    logic               advance;

    logic               s1_valid_reg;
    entry_t             s1_reg;
    logic [WW+HW-1:0]   row_prod;

    logic               s2_valid_reg;
    entry_t             s2_reg;
    logic [AW-1:0]      s2_pix_reg;
    logic [AW-1:0]      addr;

    logic               s3_valid_reg;
    entry_t             s3_reg;
    logic [AW-1:0]      s3_addr_reg;

    logic               s4_valid_reg;
    logic               s4_last_reg;
    logic               s4_invert_reg;
    logic [VALUE_W-1:0] s4_data_reg;

    logic               res_valid_reg;
    logic               res_last_reg;
    logic [VALUE_W-1:0] res_byte_reg;

    logic [VALUE_W-1:0] store_mem [DEPTH];

    assign head    = pop_data;
    // the whole pipe moves together whenever the output slot frees up
    assign advance = !res_valid_reg || result.ready;
    assign pop     = advance && !q_empty;

    assign row_prod = s1_reg.sy * frame_w;

    always_comb
    begin
        if (!s2_reg.is_read)
        begin
            addr = s2_reg.waddr;
        end
        else if (rgb)
        begin
            addr = s2_pix_reg + {s2_pix_reg[AW-2:0], 1'b0} + AW'(s2_reg.chan);
        end
        else
        begin
            addr = s2_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg && s3_reg.is_read;
            res_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg        <= head;
            s2_reg        <= s1_reg;
            s2_pix_reg    <= AW'(row_prod) + AW'(s1_reg.sx);
            s3_reg        <= s2_reg;
            s3_addr_reg   <= addr;
            s4_last_reg   <= s3_reg.last;
            s4_invert_reg <= s3_reg.invert;
            res_last_reg  <= s4_last_reg;
            res_byte_reg  <= s4_invert_reg ? (MAX_LEVEL - s4_data_reg) : s4_data_reg;
        end
    end

    // frame store: one port, write or registered read
    always_ff @(posedge clk)
    begin
        if (advance && s3_valid_reg)
        begin
            if (s3_reg.is_read)
            begin
                s4_data_reg <= store_mem[s3_addr_reg];
            end
            else
            begin
                store_mem[s3_addr_reg] <= s3_reg.value;
            end
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.pixel_byte = res_byte_reg;
    assign result.last       = res_last_reg;

endmodule

>>> hw/rtl/image_orientation_transform_unit.sv
// Frame store with transformed read-out. Load a gray (one byte per pixel) or RGB
// (three bytes per pixel) frame in raster order with write transactions (action 0);
// once the whole frame is in, each read transaction (action 1) returns the next byte
// of the frame inverted, mirrored left-right, flipped top-bottom, rotated 90 degrees
// either way or unchanged, with last set on its final byte; reads before the frame
// is complete and writes past its end return nothing and change nothing. The front
// takes one transaction per cycle while the queue is not full and hands it through
// a four-entry queue to a five-stage back end (queue capture, row multiply, byte
// address, frame store read, output register), which a read transaction passes in
// that order before its result is offered; stalls on the result side do not block
// the input until the queue fills. After reset and after every configuration write
// the front waits for the frame size and then re-derives the output coordinates of
// the saved read position with a one-bit-per-cycle divider, or restarts at the
// first byte when the saved position lies past the new frame; no transaction is
// taken meanwhile.
// The store has no clearing pass: no entry is read before it is written.
module image_orientation_transform_unit import iot_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    iot_item_if.sink      item,
    iot_result_if.source  result,
    iot_cfg_if.sink       cfg
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT * 3;
    localparam int AW      = $clog2(DEPTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int ENTRY_W = 13 + WW + HW + AW;

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               q_full;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;
    logic               q_empty;
    logic [WW-1:0]      frame_w;
    logic               rgb;

    // front: accept, classify, track write and read positions
    iot_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full),
        .frame_w   (frame_w),
        .rgb       (rgb)
    );

    // decouple front and back so each side can stall on its own
    iot_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // back: address generation, frame store access, result register
    iot_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .q_empty  (q_empty),
        .pop      (pop),
        .frame_w  (frame_w),
        .rgb      (rgb),
        .result   (result)
    );

endmodule
